### sv/string_escape_decoder_macros.svh
// Assertion macros for the string escape decoder checker.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sed_pkg.sv
// Shared types, character codes and decode helpers for the string escape decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX  = 3'd3,
		MODE_OCT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		END_QUOTE = 2'd0,
		END_EOL   = 2'd1,
		END_CAP   = 2'd2
	} end_status_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;

	typedef struct packed {
		logic [1:0] end_status;
		logic [5:0] literal_length;
		logic       last;
		logic       byte_valid;
		logic [7:0] out_byte;
	} res_t;

	// Simple escape letters map to control codes; anything else is itself.
	function automatic logic [7:0] esc_map(input logic [7:0] c);
		logic [7:0] b;
		case (c)
			8'h6E: b = 8'd10;  // n
			8'h74: b = 8'd9;   // t
			8'h72: b = 8'd13;  // r
			8'h76: b = 8'd11;  // v
			8'h66: b = 8'd12;  // f
			8'h62: b = 8'd8;   // b
			8'h61: b = 8'd7;   // a
			default: b = c;
		endcase
		return b;
	endfunction

	// {valid, nibble} for a hex digit character.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic res_t make_byte(input logic [7:0] b, input logic [5:0] len);
		res_t r;
		r.out_byte       = b;
		r.byte_valid     = 1'b1;
		r.last           = 1'b0;
		r.literal_length = len;
		r.end_status     = END_QUOTE;
		return r;
	endfunction

	function automatic res_t make_fin(input end_status_t st, input logic [5:0] len);
		res_t r;
		r.out_byte       = 8'd0;
		r.byte_valid     = 1'b0;
		r.last           = 1'b1;
		r.literal_length = len;
		r.end_status     = st;
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/string_escape_decoder.sv
// Top level of the string escape decoder: input register, decode logic, result queue.
// Depends on sed_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* channel takes one source byte per item. Bytes are ignored until a double
//   quote opens a literal; the body is then decoded (C escapes, hex, octal).
//   m_* channel gives one result per decoded byte (m_tuser high) and one final
//   result (m_tlast high, m_tuser low) carrying the end status and length.
//   Path: an accepted item is held in the input register, decoded, and written
//   into the result queue, from which it is shown on m_*.
//   Throughput: one item per cycle. An item that ends a hex or octal escape
//   can give two results; the four-entry result queue absorbs these, and the
//   input only stalls when fewer than two queue slots are free.
//   Reset: all control state clears, the block waits for an opening quote, and the
//   result queue is empty.
//   Receiver stall: results wait in the queue; when fewer than two slots are free the decode stage
//   holds its item and s_tready drops. Nothing is lost or repeated.
module string_escape_decoder import sed_pkg::*; #(
	parameter int LEN_CAP = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [13:8] literal_length, [15:14] end_status
	output logic             m_tuser,   // [0] byte_valid
	output logic             m_tlast
);

	localparam int CAP_W = $clog2(LEN_CAP + 1);
	localparam int CNT_W = (CAP_W > 6) ? CAP_W : 6;
	localparam logic [CNT_W-1:0] CAP_V = CNT_W'(LEN_CAP);

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;

	// decoder state
	mode_t            mode_q;
	logic [7:0]       acc_q;
	logic [1:0]       oct_q;
	logic [CNT_W-1:0] cnt_q;

	// result queue
	res_t        fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  fill_q;

	logic             fire;
	logic             pop;
	mode_t            mode_n;
	logic [7:0]       acc_n;
	logic [1:0]       oct_n;
	logic [CNT_W-1:0] cnt_n;
	logic [1:0]       n_res;
	res_t             r0;
	res_t             r1;
	res_t             rb;
	logic             run_body;
	logic             body_out;
	logic [4:0]       hd;
	logic             is_oct;
	logic [7:0]       oct_acc;

	assign fire     = valid_s1 && (fill_q <= 3'd2);
	assign s_tready = !valid_s1 || fire;
	assign pop      = m_tvalid && m_tready;

	assign hd      = hex_digit(char_s1);
	assign is_oct  = (char_s1 >= 8'h30) && (char_s1 <= 8'h37);
	assign oct_acc = {acc_q[4:0], char_s1[2:0]};

	always_comb begin
		mode_n   = mode_q;
		acc_n    = acc_q;
		oct_n    = oct_q;
		cnt_n    = cnt_q;
		n_res    = 2'd0;
		r0       = '0;
		r1       = '0;
		rb       = '0;
		run_body = 1'b0;
		body_out = 1'b0;
		case (mode_q)
			MODE_BODY: begin
				run_body = 1'b1;
			end
			MODE_ESC: begin
				if (char_s1 == CH_NUL) begin
					r0     = make_fin(END_EOL, cnt_q[5:0]);
					n_res  = 2'd1;
					mode_n = MODE_IDLE;
					acc_n  = 8'd0;
					oct_n  = 2'd0;
				end else if (char_s1 == CH_X) begin
					mode_n = MODE_HEX;
					acc_n  = 8'd0;
				end else if (is_oct) begin
					mode_n = MODE_OCT;
					acc_n  = {5'd0, char_s1[2:0]};
					oct_n  = 2'd1;
				end else begin
					cnt_n  = cnt_q + 1'b1;
					r0     = make_byte(esc_map(char_s1), cnt_n[5:0]);
					n_res  = 2'd1;
					mode_n = MODE_BODY;
				end
			end
			MODE_HEX: begin
				if (hd[4]) begin
					acc_n = {acc_q[3:0], hd[3:0]};
				end else begin
					// terminator: flush the value, then treat the byte as body
					cnt_n    = cnt_q + 1'b1;
					r0       = make_byte(acc_q, cnt_n[5:0]);
					n_res    = 2'd1;
					acc_n    = 8'd0;
					mode_n   = MODE_BODY;
					run_body = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					if (oct_q == 2'd2) begin
						cnt_n  = cnt_q + 1'b1;
						r0     = make_byte(oct_acc, cnt_n[5:0]);
						n_res  = 2'd1;
						acc_n  = 8'd0;
						oct_n  = 2'd0;
						mode_n = MODE_BODY;
					end else begin
						acc_n = oct_acc;
						oct_n = oct_q + 2'd1;
					end
				end else begin
					cnt_n    = cnt_q + 1'b1;
					r0       = make_byte(acc_q, cnt_n[5:0]);
					n_res    = 2'd1;
					acc_n    = 8'd0;
					oct_n    = 2'd0;
					mode_n   = MODE_BODY;
					run_body = 1'b1;
				end
			end
			default: begin
				// idle, and any unused mode code
				mode_n = MODE_IDLE;
				if (char_s1 == CH_QUOTE) begin
					mode_n = MODE_BODY;
					cnt_n  = '0;
					acc_n  = 8'd0;
					oct_n  = 2'd0;
				end
			end
		endcase

		// ordinary body byte, after any escape flush above
		if (run_body) begin
			if (char_s1 == CH_QUOTE || char_s1 == CH_NUL || cnt_n >= CAP_V) begin
				if (char_s1 == CH_QUOTE) begin
					rb = make_fin(END_QUOTE, cnt_n[5:0]);
				end else if (char_s1 == CH_NUL) begin
					rb = make_fin(END_EOL, cnt_n[5:0]);
				end else begin
					rb = make_fin(END_CAP, cnt_n[5:0]);
				end
				body_out = 1'b1;
				mode_n   = MODE_IDLE;
				acc_n    = 8'd0;
				oct_n    = 2'd0;
			end else if (char_s1 == CH_BSLASH) begin
				mode_n = MODE_ESC;
			end else begin
				cnt_n    = cnt_n + 1'b1;
				rb       = make_byte(char_s1, cnt_n[5:0]);
				body_out = 1'b1;
			end
			if (body_out) begin
				if (n_res == 2'd0) begin
					r0 = rb;
				end else begin
					r1 = rb;
				end
				n_res = n_res + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			acc_q    <= 8'd0;
			oct_q    <= 2'd0;
			cnt_q    <= '0;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			fill_q   <= 3'd0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (fire) begin
				mode_q   <= mode_n;
				acc_q    <= acc_n;
				oct_q    <= oct_n;
				cnt_q    <= cnt_n;
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			fill_q <= fill_q + (fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
		if (fire && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (fire && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	assign m_tvalid = (fill_q != 3'd0);
	assign m_tdata  = {fifo_q[rd_ptr_q].end_status, fifo_q[rd_ptr_q].literal_length,
		fifo_q[rd_ptr_q].out_byte};
	assign m_tuser  = fifo_q[rd_ptr_q].byte_valid;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

### sv/sed_checker.sv
// Port-level checker for the string escape decoder, bound to the top level.
// Depends on string_escape_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "string_escape_decoder_macros.svh"

module sed_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	logic unused_in;
	assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

	`SED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"stalled result changed")

	`SED_ASSERT_NOW(a_byte_not_last, m_tvalid && m_tuser,
		!m_tlast && m_tdata[15:14] == 2'd0, "byte item carries end marking")

	`SED_ASSERT_NOW(a_end_item_form, m_tvalid && !m_tuser,
		m_tlast && m_tdata[7:0] == 8'd0 && m_tdata[15:14] != 2'd3,
		"malformed end item")

	`SED_ASSERT_NEXT(a_len_step, m_tvalid && m_tready && m_tuser && !m_tlast,
		!m_tvalid || !m_tuser || m_tdata[13:8] == $past(m_tdata[13:8]) + 6'd1,
		"byte count did not advance by one")

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
